// ----- hdl/assert_macros.svh -----
// Assertion macros used by the sequencer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property check on clk_i, off while rst_ni is low
`define SHMSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen
`define SHMSC_NEVER(label, expr, msg) \
  `SHMSC_ASSERT(label, !(expr), msg)

`endif

// ----- hdl/shmsc_pkg.sv -----
// Package: shared types and constants of the stepper homing sequencer
`default_nettype none

package shmsc_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_PUSH   = 3'd1,
    OP_PULL   = 3'd2,
    OP_FILL   = 3'd3,
    OP_REHOME = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_REJECT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_STEPS_PER_VOLUME = 2'd0,
    CFG_MAX_POSITION     = 2'd1,
    CFG_PUSH_TIMEOUT     = 2'd2,
    CFG_PULL_TIMEOUT     = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] RstStepsPerVolume = 16'd350;
  localparam logic [30:0] RstMaxPosition    = 31'd65000;
  localparam logic [31:0] RstPushTimeout    = 32'd240000;
  localparam logic [31:0] RstPullTimeout    = 32'd180000;

  typedef struct packed {
    logic [15:0] steps_per_volume;
    logic [30:0] max_position;
    logic [31:0] push_phase_timeout;
    logic [31:0] pull_phase_timeout;
  } cfg_t;

  typedef struct packed {
    logic               step_pulse;
    logic               direction_push;
    logic               driver_enabled;
    logic               busy_res;
    logic               job_done;
    status_e            status_code;
    logic signed [31:0] position_out;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/stepper_homing_motion_sequencer_core.sv -----
// Top level: stepper homing sequencer with input word register and result register
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per command or step
//   slot: operation_i (0 tick, 1 push, 2 pull, 3 fill, 4 rehome; 5..7 act as tick),
//   amount_ml_i for push and pull, home_active_i sampled on ticks.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result word
//   per input word, in order: step pulse, direction, driver enable, busy, done,
//   status and the position after that word.
//   Path: an accepted word goes from the input register to the result register
//   (two register stages), through a combinational job update. Throughput: one
//   word per cycle while the result register is empty or being taken.
//   Stall: while the result register holds an untaken word the input register
//   still fills; once both are full in_stall_o follows out_stall_i.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 steps/ml, 1 max position, 2 push timeout, 3 pull timeout); write only
//   while the block is idle.
//   Reset (rst_ni low, async): both stages empty, position 0, no job, and the
//   configuration back to its defaults.
`default_nettype none

module stepper_homing_motion_sequencer_core import shmsc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // input words
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [2:0]          operation_i,
  input  wire logic [15:0]         amount_ml_i,
  input  wire logic                home_active_i,
  // result words
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic                step_pulse_o,
  output      logic                direction_push_o,
  output      logic                driver_enabled_o,
  output      logic                busy_res_o,
  output      logic                job_done_o,
  output      logic [1:0]          status_code_o,
  output      logic signed [31:0]  position_out_o
);

`include "assert_macros.svh"

  cfg_t    cfg;
  result_t res;

  // input word register
  logic        in_valid_q;
  logic [2:0]  op_q;
  logic [15:0] amt_q;
  logic        home_q;

  // result register
  logic        out_valid_q;
  result_t     out_q;

  logic        adv;    // held word moves into the result register
  logic        in_acc;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  shmsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // job state only moves when the word commits
  shmsc_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .operation_i   (op_q),
    .amount_ml_i   (amt_q),
    .home_active_i (home_q),
    .cfg_i         (cfg),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= operation_i;
      amt_q  <= amount_ml_i;
      home_q <= home_active_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_pulse_o     = out_q.step_pulse;
  assign direction_push_o = out_q.direction_push;
  assign driver_enabled_o = out_q.driver_enabled;
  assign busy_res_o       = out_q.busy_res;
  assign job_done_o       = out_q.job_done;
  assign status_code_o    = out_q.status_code;
  assign position_out_o   = out_q.position_out;

  `SHMSC_NEVER(a_done_not_busy, out_valid_q && out_q.job_done && out_q.busy_res, "done word still busy")
  `SHMSC_ASSERT(a_reject_shape, (out_valid_q && out_q.status_code == ST_REJECT) |-> (out_q.busy_res && out_q.driver_enabled && !out_q.step_pulse && !out_q.job_done), "bad rejected word")
  `SHMSC_NEVER(a_step_needs_enable, out_valid_q && out_q.step_pulse && !out_q.driver_enabled, "step without driver enable")
  `SHMSC_ASSERT(a_held_word_kept, (in_valid_q && !adv) |=> in_valid_q, "held input word lost")

endmodule

`default_nettype wire

// ----- hdl/shmsc_cfg_regs.sv -----
// Configuration register file of the stepper homing sequencer
`default_nettype none

module shmsc_cfg_regs import shmsc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_volume   <= RstStepsPerVolume;
      cfg_q.max_position       <= RstMaxPosition;
      cfg_q.push_phase_timeout <= RstPushTimeout;
      cfg_q.pull_phase_timeout <= RstPullTimeout;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEPS_PER_VOLUME: cfg_q.steps_per_volume   <= cfg_data_i[15:0];
        CFG_MAX_POSITION:     cfg_q.max_position       <= cfg_data_i[30:0];
        CFG_PUSH_TIMEOUT:     cfg_q.push_phase_timeout <= cfg_data_i;
        CFG_PULL_TIMEOUT:     cfg_q.pull_phase_timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/shmsc_engine.sv -----
// Job state machine: position, step count, phase timer and per-word result
`default_nettype none

module shmsc_engine import shmsc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,      // commit the held word this cycle
  input  wire logic [2:0]  operation_i,
  input  wire logic [15:0] amount_ml_i,
  input  wire logic        home_active_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_PUSH     = 3'd1,
    MODE_PULL     = 3'd2,
    MODE_FILL     = 3'd3,
    MODE_RH_START = 3'd4,
    MODE_RH_PUSH  = 3'd5,
    MODE_RH_PULL  = 3'd6
  } mode_e;

  localparam logic signed [31:0] PosMin = 32'sh8000_0000;

  mode_e              mode_q, mode_d;
  logic signed [31:0] pos_q, pos_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        elapsed_q, elapsed_d;

  always_comb begin
    logic        is_cmd;
    logic        home;
    logic        fin;
    status_e     fin_code;
    logic [31:0] rem_dec;
    logic [31:0] cnt_base;
    logic [31:0] cnt_inc;
    logic [31:0] cnt_limit;
    logic        cnt_en;
    logic        at_limit;

    is_cmd    = (operation_i == OP_PUSH) || (operation_i == OP_PULL) ||
                (operation_i == OP_FILL) || (operation_i == OP_REHOME);
    home      = home_active_i;
    fin       = 1'b0;
    fin_code  = ST_OK;
    cnt_en    = 1'b0;
    cnt_base  = elapsed_q;
    cnt_limit = cfg_i.push_phase_timeout;
    rem_dec   = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;
    at_limit  = pos_q >= $signed({1'b0, cfg_i.max_position});

    mode_d    = mode_q;
    pos_d     = pos_q;
    rem_d     = rem_q;
    elapsed_d = elapsed_q;

    res_o.step_pulse     = 1'b0;
    res_o.direction_push = 1'b0;
    res_o.driver_enabled = 1'b0;
    res_o.job_done       = 1'b0;
    res_o.status_code    = ST_OK;

    if (is_cmd) begin
      res_o.driver_enabled = 1'b1;
      if (mode_q != MODE_IDLE) begin
        res_o.status_code    = ST_REJECT;
        res_o.direction_push = (mode_q == MODE_PUSH) || (mode_q == MODE_RH_PUSH);
      end else begin
        case (op_e'(operation_i))
          OP_PUSH, OP_PULL: begin
            rem_d  = {16'd0, amount_ml_i} * {16'd0, cfg_i.steps_per_volume};
            mode_d = (operation_i == OP_PUSH) ? MODE_PUSH : MODE_PULL;
            res_o.direction_push = (operation_i == OP_PUSH);
            // product is zero exactly when either factor is
            fin = (amount_ml_i == 16'd0) || (cfg_i.steps_per_volume == 16'd0);
          end
          OP_FILL: mode_d = MODE_FILL;
          default: begin
            mode_d               = MODE_RH_START;
            elapsed_d            = 32'd0;
            res_o.direction_push = 1'b1;
          end
        endcase
      end
    end else if (mode_q != MODE_IDLE) begin
      res_o.driver_enabled = 1'b1;
      case (mode_q)
        MODE_PUSH: begin
          res_o.direction_push = 1'b1;
          if (home) begin
            pos_d = '0;
            fin   = 1'b1;
          end else begin
            res_o.step_pulse = 1'b1;
            if (pos_q != PosMin) pos_d = pos_q - 32'sd1;
            rem_d = rem_dec;
            fin   = (rem_dec == 32'd0);
          end
        end
        MODE_PULL, MODE_FILL: begin
          if (at_limit) begin
            pos_d = $signed({1'b0, cfg_i.max_position});
            fin   = 1'b1;
          end else begin
            res_o.step_pulse = 1'b1;
            pos_d = pos_q + 32'sd1;
            if (mode_q == MODE_PULL) begin
              rem_d = rem_dec;
              fin   = (rem_dec == 32'd0);
            end
          end
        end
        MODE_RH_START: begin
          res_o.step_pulse = home;
          cnt_en           = home;
          if (home) begin
            // already home: this slot is the first pull-phase slot
            mode_d    = MODE_RH_PULL;
            cnt_base  = 32'd0;
            cnt_limit = cfg_i.pull_phase_timeout;
            cnt_en    = 1'b1;
          end else begin
            mode_d               = MODE_RH_PUSH;
            res_o.direction_push = 1'b1;
            res_o.step_pulse     = 1'b1;
            cnt_en               = 1'b1;
          end
        end
        MODE_RH_PUSH: begin
          res_o.direction_push = 1'b1;
          res_o.step_pulse     = 1'b1;
          if (home) begin
            elapsed_d = 32'd0;
            mode_d    = MODE_RH_PULL;
          end else begin
            cnt_en = 1'b1;
          end
        end
        MODE_RH_PULL: begin
          if (home) begin
            res_o.step_pulse = 1'b1;
            cnt_limit        = cfg_i.pull_phase_timeout;
            cnt_en           = 1'b1;
          end else begin
            pos_d = '0;
            fin   = 1'b1;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase
    end

    // saturating phase timer and timeout check
    cnt_inc = (cnt_base != 32'hFFFF_FFFF) ? cnt_base + 32'd1 : cnt_base;
    if (cnt_en) begin
      elapsed_d = cnt_inc;
      if (cnt_inc >= cnt_limit) begin
        fin      = 1'b1;
        fin_code = ST_TIMEOUT;
      end
    end

    if (fin) begin
      mode_d            = MODE_IDLE;
      rem_d             = 32'd0;
      elapsed_d         = 32'd0;
      res_o.job_done    = 1'b1;
      res_o.status_code = fin_code;
    end

    res_o.busy_res     = (mode_d != MODE_IDLE);
    res_o.position_out = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      pos_q     <= '0;
      rem_q     <= '0;
      elapsed_q <= '0;
    end else if (adv_i) begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      rem_q     <= rem_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_stepper_homing_motion_sequencer_core.sv -----
// Testbench for the stepper homing sequencer: directed table plus random jobs, checked by predictor
module tb_stepper_homing_motion_sequencer_core import shmsc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Job state of the predictor; the package has no type for it.
  typedef enum logic [2:0] {
    JOB_IDLE,
    JOB_PUSH,
    JOB_PULL,
    JOB_FILL,
    JOB_RH_START,
    JOB_RH_PUSH,
    JOB_RH_PULL
  } job_e;

  // One line of the directed table: a register write or an input word.
  // A word with typed set carries its expected result; otherwise the predictor decides.
  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [31:0] data;
    logic [2:0]  op;
    logic [15:0] amt;
    logic        home;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [2:0]          operation_i      = '0;
  logic [15:0]         amount_ml_i      = '0;
  logic                home_active_i    = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic                step_pulse_o;
  logic                direction_push_o;
  logic                driver_enabled_o;
  logic                busy_res_o;
  logic                job_done_o;
  logic [1:0]          status_code_o;
  logic signed [31:0]  position_out_o;

  stepper_homing_motion_sequencer_core dut (.*);

  // Predictor copy of the configuration, starting at the reset defaults.
  logic [15:0]        cfg_spv        = RstStepsPerVolume;
  logic [30:0]        cfg_max_pos    = RstMaxPosition;
  logic [31:0]        cfg_push_limit = RstPushTimeout;
  logic [31:0]        cfg_pull_limit = RstPullTimeout;

  // Predictor copy of the job state.
  logic signed [31:0] plunger_pos    = '0;
  logic [31:0]        steps_left     = '0;
  job_e               job            = JOB_IDLE;
  logic [31:0]        phase_slots    = '0;

  // Per-word outputs that the slot handlers set.
  logic               w_step;
  logic               w_dir;
  logic               w_done;
  status_e            w_status;

  result_t            pending_words[$];
  int                 mismatches     = 0;
  bit                 calm           = 1'b0;  // no idling on either side
  int                 hold_req       = 0;     // receiver hold-off request, in cycles
  int                 hold_left      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb_stepper_homing_motion_sequencer_core failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void end_job(status_e code);
    job         = JOB_IDLE;
    steps_left  = '0;
    phase_slots = '0;
    w_done      = 1'b1;
    w_status    = code;
  endfunction

  // Rehome phase slot counter: saturates, and a full count is a timeout.
  function automatic void count_phase_slot(logic [31:0] limit);
    if (phase_slots != 32'hFFFF_FFFF) phase_slots = phase_slots + 1;
    if (phase_slots >= limit) end_job(ST_TIMEOUT);
  endfunction

  function automatic void push_slot(logic home);
    w_dir = 1'b1;
    if (home) begin
      plunger_pos = '0;
      end_job(ST_OK);
    end else begin
      w_step = 1'b1;
      if (plunger_pos != 32'sh8000_0000) plunger_pos = plunger_pos - 1;  // floor
      if (steps_left != 0) steps_left = steps_left - 1;
      if (steps_left == 0) end_job(ST_OK);
    end
  endfunction

  // Fill is a pull that ignores the step count and stops only at the limit.
  function automatic void pull_slot(bit counted);
    w_dir = 1'b0;
    if (plunger_pos >= $signed({1'b0, cfg_max_pos})) begin
      plunger_pos = $signed({1'b0, cfg_max_pos});
      end_job(ST_OK);
    end else begin
      w_step      = 1'b1;
      plunger_pos = plunger_pos + 1;
      if (counted) begin
        if (steps_left != 0) steps_left = steps_left - 1;
        if (steps_left == 0) end_job(ST_OK);
      end
    end
  endfunction

  // Back off while home holds; release of the switch is the zero point.
  function automatic void rehome_pull_slot(logic home);
    w_dir = 1'b0;
    if (home) begin
      w_step = 1'b1;
      count_phase_slot(cfg_pull_limit);
    end else begin
      plunger_pos = '0;
      end_job(ST_OK);
    end
  endfunction

  function automatic result_t next_motion_word(logic [2:0] op, logic [15:0] amt, logic home);
    result_t r;
    logic    enabled;
    w_step   = 1'b0;
    w_dir    = 1'b0;
    w_done   = 1'b0;
    w_status = ST_OK;
    enabled  = 1'b0;
    if (op >= OP_PUSH && op <= OP_REHOME) begin
      enabled = 1'b1;
      if (job != JOB_IDLE) begin
        w_status = ST_REJECT;
        w_dir    = (job == JOB_PUSH || job == JOB_RH_PUSH);
      end else begin
        case (op)
          OP_PUSH, OP_PULL: begin
            steps_left = {16'd0, amt} * {16'd0, cfg_spv};
            job        = (op == OP_PUSH) ? JOB_PUSH : JOB_PULL;
            w_dir      = (op == OP_PUSH);
            if (steps_left == 0) end_job(ST_OK);
          end
          OP_FILL: job = JOB_FILL;
          default: begin
            job         = JOB_RH_START;
            phase_slots = '0;
            w_dir       = 1'b1;
          end
        endcase
      end
    end else if (job != JOB_IDLE) begin
      enabled = 1'b1;
      case (job)
        JOB_PUSH: push_slot(home);
        JOB_PULL: pull_slot(1'b1);
        JOB_FILL: pull_slot(1'b0);
        JOB_RH_START: begin
          if (home) begin
            // already on the switch: skip the push phase and the extra step
            phase_slots = '0;
            job         = JOB_RH_PULL;
            rehome_pull_slot(home);
          end else begin
            job    = JOB_RH_PUSH;
            w_dir  = 1'b1;
            w_step = 1'b1;
            count_phase_slot(cfg_push_limit);
          end
        end
        JOB_RH_PUSH: begin
          w_dir  = 1'b1;
          w_step = 1'b1;
          if (home) begin
            // this is the extra step past the switch
            phase_slots = '0;
            job         = JOB_RH_PULL;
          end else begin
            count_phase_slot(cfg_push_limit);
          end
        end
        default: rehome_pull_slot(home);
      endcase
    end
    r.step_pulse     = w_step;
    r.direction_push = w_dir;
    r.driver_enabled = enabled;
    r.busy_res       = (job != JOB_IDLE);
    r.job_done       = w_done;
    r.status_code    = w_status;
    r.position_out   = plunger_pos;
    return r;
  endfunction

  // ---------------------------------------------------------------- table rows

  function automatic result_t motion_word(int s, int d, int e, int b, int dn,
                                          status_e st, int pos);
    result_t r;
    r.step_pulse     = 1'(s);
    r.direction_push = 1'(d);
    r.driver_enabled = 1'(e);
    r.busy_res       = 1'(b);
    r.job_done       = 1'(dn);
    r.status_code    = st;
    r.position_out   = pos;
    return r;
  endfunction

  function automatic plan_row_t word_row(logic [2:0] op, logic [15:0] amt, logic home,
                                         bit typed = 1'b0, result_t want = '0);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = CFG_STEPS_PER_VOLUME;
    r.data   = '0;
    r.op     = op;
    r.amt    = amt;
    r.home   = home;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_idx_e idx, logic [31:0] data);
    plan_row_t r;
    r        = word_row(OP_TICK, '0, 1'b0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  // Offer one word, hold it until taken, then record what it should produce.
  task automatic send_word(logic [2:0] op, logic [15:0] amt, logic home,
                           bit typed = 1'b0, result_t want = '0);
    result_t predicted;
    if (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    amount_ml_i   <= amt;
    home_active_i <= home;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = next_motion_word(op, amt, home);
    pending_words.push_back(typed ? want : predicted);
  endtask

  // Every result back, then wait for the two register stages to empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_register(cfg_idx_e idx, logic [31:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_STEPS_PER_VOLUME: cfg_spv        = data[15:0];
      CFG_MAX_POSITION:     cfg_max_pos    = data[30:0];
      CFG_PUSH_TIMEOUT:     cfg_push_limit = data;
      default:              cfg_pull_limit = data;
    endcase
  endtask

  // One random phase: mostly whole jobs with random content, some rejected
  // commands and unused codes as noise; then ticks that bring the job home.
  task automatic run_phase(logic [15:0] spv, logic [30:0] max_pos, logic [31:0] push_lim,
                           logic [31:0] pull_lim, int max_amt, bit fill_ok, bit squeeze,
                           int n_words);
    int         taken;
    int         roll;
    bit         live;
    logic [2:0] op;
    logic       home_lvl;
    logic       home;
    program_register(CFG_STEPS_PER_VOLUME, {16'd0, spv});
    program_register(CFG_MAX_POSITION, {1'b0, max_pos});
    program_register(CFG_PUSH_TIMEOUT, push_lim);
    program_register(CFG_PULL_TIMEOUT, pull_lim);
    calm = squeeze;
    if (squeeze) hold_req = 64;  // receiver blocks, sender keeps offering
    taken    = 0;
    home_lvl = 1'b0;
    while (taken < n_words) begin
      roll = $urandom_range(99);
      // the switch level moves in runs so that rehome phases play out
      if ($urandom_range(99) < 18) home_lvl = !home_lvl;
      if ((job == JOB_IDLE && roll < 60) || roll < 6) begin
        op = 3'($urandom_range(4, 1));
        if (op == OP_FILL && !fill_ok) op = OP_PULL;
        live = 1'b1;
        send_word(op, 16'($urandom_range(max_amt)), 1'($urandom));
      end else begin
        op   = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : OP_TICK;
        live = (job != JOB_IDLE);
        home = live ? home_lvl : 1'($urandom);
        send_word(op, 16'($urandom), home);
      end
      if (live) taken++;
    end
    while (job != JOB_IDLE) begin
      case (job)
        JOB_PUSH, JOB_RH_START, JOB_RH_PUSH: home = 1'b1;
        JOB_RH_PULL:                         home = 1'b0;
        default:                             home = 1'($urandom);
      endcase
      send_word(OP_TICK, 16'($urandom), home);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(string field, logic signed [32:0] want, logic signed [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Result side: check each taken word, then pick the stall for the next cycle.
  initial begin
    result_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          $error("result word with no expectation pending");
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          check_field("step_pulse", 33'(want.step_pulse), 33'(step_pulse_o));
          check_field("direction_push", 33'(want.direction_push), 33'(direction_push_o));
          check_field("driver_enabled", 33'(want.driver_enabled), 33'(driver_enabled_o));
          check_field("busy_res", 33'(want.busy_res), 33'(busy_res_o));
          check_field("job_done", 33'(want.job_done), 33'(job_done_o));
          check_field("status_code", 33'(want.status_code), 33'(status_code_o));
          check_field("position_out", 33'(want.position_out), 33'(position_out_o));
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 30);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    plan_row_t plan_q[$];
    plan_q = '{
      // reset configuration: idle words and zero-volume jobs
      word_row(OP_TICK, 16'h0000, 1'b0, 1'b1, motion_word(0, 0, 0, 0, 0, ST_OK, 0)),
      word_row(3'd7, 16'hFFFF, 1'b1, 1'b1, motion_word(0, 0, 0, 0, 0, ST_OK, 0)),
      word_row(OP_PUSH, 16'h0000, 1'b0, 1'b1, motion_word(0, 1, 1, 0, 1, ST_OK, 0)),
      word_row(OP_PULL, 16'h0000, 1'b1, 1'b1, motion_word(0, 0, 1, 0, 1, ST_OK, 0)),
      // tight limits, steps per ml at its top
      cfg_row(CFG_MAX_POSITION, 32'd2),
      cfg_row(CFG_STEPS_PER_VOLUME, 32'd65535),
      cfg_row(CFG_PUSH_TIMEOUT, 32'd3),
      cfg_row(CFG_PULL_TIMEOUT, 32'd2),
      // fill up to the limit, with a rejected command on the way
      word_row(OP_FILL, 16'h0000, 1'b0, 1'b1, motion_word(0, 0, 1, 1, 0, ST_OK, 0)),
      word_row(OP_REHOME, 16'h0000, 1'b0, 1'b1, motion_word(0, 0, 1, 1, 0, ST_REJECT, 0)),
      word_row(OP_TICK, 16'h0000, 1'b0),
      word_row(OP_TICK, 16'h0000, 1'b0),
      word_row(3'd6, 16'h0000, 1'b0),
      // largest pull already at the limit
      word_row(OP_PULL, 16'hFFFF, 1'b0),
      word_row(3'd5, 16'h0000, 1'b0),
      // largest push, rejected push, then the home switch ends it
      word_row(OP_PUSH, 16'hFFFF, 1'b0),
      word_row(OP_PUSH, 16'h0001, 1'b0, 1'b1, motion_word(0, 1, 1, 1, 0, ST_REJECT, 2)),
      word_row(OP_TICK, 16'h0000, 1'b0),
      word_row(OP_TICK, 16'h0000, 1'b1),
      // rehome that never finds home: push phase timeout
      word_row(OP_REHOME, 16'h0000, 1'b0),
      word_row(OP_TICK, 16'h0000, 1'b0),
      word_row(OP_TICK, 16'h0000, 1'b0),
      word_row(OP_TICK, 16'h0000, 1'b0, 1'b1, motion_word(1, 1, 1, 0, 1, ST_TIMEOUT, 0)),
      // rehome starting on the switch that never releases: pull phase timeout
      word_row(OP_REHOME, 16'h0000, 1'b0),
      word_row(OP_TICK, 16'h0000, 1'b1),
      word_row(OP_TICK, 16'h0000, 1'b1),
      // full rehome: push, extra step, back off, release
      word_row(OP_REHOME, 16'h0000, 1'b0),
      word_row(OP_TICK, 16'h0000, 1'b0),
      word_row(OP_TICK, 16'h0000, 1'b1),
      word_row(OP_TICK, 16'h0000, 1'b1),
      word_row(OP_TICK, 16'h0000, 1'b0)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        program_register(plan_q[i].idx, plan_q[i].data);
      end else begin
        send_word(plan_q[i].op, plan_q[i].amt, plan_q[i].home, plan_q[i].typed,
                  plan_q[i].want);
      end
    end

    // spv, max pos, push limit, pull limit, max ml, fill, squeeze, words
    run_phase(16'd1, 31'd40, 32'd20, 32'd6, 12, 1'b1, 1'b1, 60);
    run_phase(16'd2, 31'd1, 32'd1, 32'd1, 5, 1'b1, 1'b0, 60);
    run_phase(16'd3, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4, 1'b0, 1'b0, 60);
    run_phase(16'd65535, 31'd100, 32'd5, 32'd3, 1, 1'b1, 1'b0, 60);
    run_phase(RstStepsPerVolume, 31'd30, RstPushTimeout, RstPullTimeout, 2, 1'b1, 1'b0, 60);
    run_phase(16'd1, 31'd3, 32'd2, 32'd2, 65535, 1'b1, 1'b0, 60);

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb_stepper_homing_motion_sequencer_core passed");
    end else begin
      $display("tb_stepper_homing_motion_sequencer_core failed");
    end
    $finish;
  end

endmodule

// ----- stepper_homing_motion_sequencer_core.f -----
+incdir+hdl
hdl/shmsc_pkg.sv
hdl/shmsc_cfg_regs.sv
hdl/shmsc_engine.sv
hdl/stepper_homing_motion_sequencer_core.sv
sim/tb_stepper_homing_motion_sequencer_core.sv
